### sv/utf8_stream_decoder_validator_macros.svh
// Assertion helpers for the UTF-8 decoder.
`ifndef UTF8_STREAM_DECODER_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_DECODER_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/u8dec_pkg.sv
package u8dec_pkg;

  localparam int CpW  = 21;
  localparam int StW  = 3;
  localparam int WidW = 3;

  localparam logic [StW-1:0] ST_OK          = 3'd0;
  localparam logic [StW-1:0] ST_BAD_START   = 3'd1;
  localparam logic [StW-1:0] ST_EXPECT_CONT = 3'd2;
  localparam logic [StW-1:0] ST_BAD_CP      = 3'd3;
  localparam logic [StW-1:0] ST_OVERLONG    = 3'd4;
  localparam logic [StW-1:0] ST_TRUNCATED   = 3'd5;

  localparam logic [CpW-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CpW-1:0] NONCH_LO   = 21'h00FDD0;
  localparam logic [CpW-1:0] NONCH_HI   = 21'h00FDEF;
  localparam logic [15:0]    NONCH_TAIL = 16'hFFFE;
  localparam logic [CpW-1:0] MAX_W1     = 21'h00007F;
  localparam logic [CpW-1:0] MAX_W2     = 21'h0007FF;
  localparam logic [CpW-1:0] MAX_W3     = 21'h00FFFF;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [StW-1:0]  status;
    logic [WidW-1:0] seq_width;
    logic            last;
  } res_t;

endpackage

### sv/utf8_stream_decoder_validator.sv
// UTF-8 byte stream decoder and validator.
// Pipeline: an input register feeds a result register.
// Throughput: one byte per cycle unless the result side stalls; the decode path is one classify and shift-merge step.
// A byte that only extends a sequence gives no result transaction.
// Reset (synchronous, rst_n low) closes any open sequence and empties both registers.
`include "utf8_stream_decoder_validator_macros.svh"

module utf8_stream_decoder_validator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_end_of_string,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [u8dec_pkg::CpW-1:0]      out_code_point,
  output logic [u8dec_pkg::StW-1:0]      out_status,
  output logic [u8dec_pkg::WidW-1:0]     out_seq_width,
  output logic                           out_last
);

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eos_r;
  logic       s1_adv;

  // decoder state
  logic [u8dec_pkg::CpW-1:0]  part_r,  part_nxt;
  logic [1:0]                 rem_r,   rem_nxt;
  logic [u8dec_pkg::WidW-1:0] len_r,   len_nxt;

  // result stage
  logic            out_valid_r;
  u8dec_pkg::res_t out_r;
  u8dec_pkg::res_t res_nxt;
  logic            emit_nxt;

  logic                       is_ascii, is_cont, lead2, lead3, lead4;
  logic [u8dec_pkg::CpW-1:0]  cp_cat;
  logic [1:0]                 rem_dec;
  logic                       cp_bad;
  logic [u8dec_pkg::WidW-1:0] min_w;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign is_ascii = !s1_byte_r[7];
  assign is_cont  = (s1_byte_r[7:6] == 2'b10);
  assign lead2    = (s1_byte_r >= u8dec_pkg::LEAD2_LO) && (s1_byte_r <= u8dec_pkg::LEAD2_HI);
  assign lead3    = (s1_byte_r[7:4] == 4'hE);
  assign lead4    = (s1_byte_r >= u8dec_pkg::LEAD4_LO) && (s1_byte_r <= u8dec_pkg::LEAD4_HI);
  assign cp_cat   = {part_r[u8dec_pkg::CpW-7:0], s1_byte_r[5:0]};
  assign rem_dec  = rem_r - 2'd1;

  assign cp_bad = (cp_cat > u8dec_pkg::CP_MAX)
               || ((cp_cat >= u8dec_pkg::SURR_LO) && (cp_cat <= u8dec_pkg::SURR_HI))
               || ((cp_cat >= u8dec_pkg::NONCH_LO) && (cp_cat <= u8dec_pkg::NONCH_HI))
               || ((cp_cat[15:0] & u8dec_pkg::NONCH_TAIL) == u8dec_pkg::NONCH_TAIL);

  always_comb begin
    if (cp_cat <= u8dec_pkg::MAX_W1) begin
      min_w = 3'd1;
    end else if (cp_cat <= u8dec_pkg::MAX_W2) begin
      min_w = 3'd2;
    end else if (cp_cat <= u8dec_pkg::MAX_W3) begin
      min_w = 3'd3;
    end else begin
      min_w = 3'd4;
    end
  end

  always_comb begin
    part_nxt           = part_r;
    rem_nxt            = rem_r;
    len_nxt            = len_r;
    emit_nxt           = 1'b0;
    res_nxt.code_point = '0;
    res_nxt.status     = u8dec_pkg::ST_OK;
    res_nxt.seq_width  = '0;
    res_nxt.last       = s1_eos_r;
    if (rem_r == 2'd0) begin
      if (is_ascii) begin
        emit_nxt           = 1'b1;
        res_nxt.code_point = {13'd0, s1_byte_r};
        res_nxt.seq_width  = 3'd1;
      end else if (lead2 || lead3 || lead4) begin
        if (lead2) begin
          part_nxt = {16'd0, s1_byte_r[4:0]};
          rem_nxt  = 2'd1;
          len_nxt  = 3'd2;
        end else if (lead3) begin
          part_nxt = {17'd0, s1_byte_r[3:0]};
          rem_nxt  = 2'd2;
          len_nxt  = 3'd3;
        end else begin
          part_nxt = {18'd0, s1_byte_r[2:0]};
          rem_nxt  = 2'd3;
          len_nxt  = 3'd4;
        end
        // end of string right after a lead byte: drop the sequence and report it truncated
        if (s1_eos_r) begin
          part_nxt       = '0;
          rem_nxt        = 2'd0;
          len_nxt        = '0;
          emit_nxt       = 1'b1;
          res_nxt.status = u8dec_pkg::ST_TRUNCATED;
        end
      end else begin
        emit_nxt       = 1'b1;
        res_nxt.status = u8dec_pkg::ST_BAD_START;
      end
    end else if (!is_cont) begin
      part_nxt       = '0;
      rem_nxt        = 2'd0;
      len_nxt        = '0;
      emit_nxt       = 1'b1;
      res_nxt.status = u8dec_pkg::ST_EXPECT_CONT;
    end else if (rem_dec != 2'd0) begin
      part_nxt = cp_cat;
      rem_nxt  = rem_dec;
      if (s1_eos_r) begin
        part_nxt       = '0;
        rem_nxt        = 2'd0;
        len_nxt        = '0;
        emit_nxt       = 1'b1;
        res_nxt.status = u8dec_pkg::ST_TRUNCATED;
      end
    end else begin
      part_nxt = '0;
      rem_nxt  = 2'd0;
      len_nxt  = '0;
      emit_nxt = 1'b1;
      if (cp_bad) begin
        res_nxt.status = u8dec_pkg::ST_BAD_CP;
      end else if (min_w != len_r) begin
        res_nxt.status = u8dec_pkg::ST_OVERLONG;
      end else begin
        res_nxt.code_point = cp_cat;
        res_nxt.seq_width  = len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      part_r      <= '0;
      rem_r       <= 2'd0;
      len_r       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= s1_adv && emit_nxt;
      end
      if (s1_adv) begin
        part_r <= part_nxt;
        rem_r  <= rem_nxt;
        len_r  <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_eos_r  <= in_end_of_string;
    end
    if (s1_adv && emit_nxt) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_r.code_point;
  assign out_status     = out_r.status;
  assign out_seq_width  = out_r.seq_width;
  assign out_last       = out_r.last;

  `U8D_ASSERT_NOW(a_err_zero, out_valid_r && (out_r.status != u8dec_pkg::ST_OK), (out_r.code_point == '0) && (out_r.seq_width == '0), "error result carries data")
  `U8D_ASSERT_NOW(a_ok_width, out_valid_r && (out_r.status == u8dec_pkg::ST_OK), (out_r.seq_width == 3'd1) || (out_r.seq_width == 3'd2) || (out_r.seq_width == 3'd3) || (out_r.seq_width == 3'd4), "ok result with bad width")
  `U8D_ASSERT_NOW(a_ascii_range, out_valid_r && (out_r.status == u8dec_pkg::ST_OK) && (out_r.seq_width == 3'd1), out_r.code_point <= u8dec_pkg::MAX_W1, "one-byte result out of range")
  `U8D_ASSERT_NOW(a_idle_clear, rem_r == 2'd0, (len_r == '0) && (part_r == '0), "stale state with no open sequence")
  `U8D_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ready, s1_valid_r && $stable(s1_byte_r) && $stable(s1_eos_r), "input stage lost a stalled byte")

endmodule

### sim/tb_utf8_stream_decoder_validator.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_validator;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [7:0]  LEAD3_LO    = 8'hE0;
  localparam logic [7:0]  LEAD3_HI    = 8'hEF;

  typedef logic [u8dec_pkg::CpW-1:0] cp_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_data_byte = 8'h00;
  logic                          in_end_of_string = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [u8dec_pkg::CpW-1:0]     out_code_point;
  logic [u8dec_pkg::StW-1:0]     out_status;
  logic [u8dec_pkg::WidW-1:0]    out_seq_width;
  logic                          out_last;

  // Decoder state mirrored by the predictor.
  logic [u8dec_pkg::CpW-1:0]  dec_acc = '0;
  logic [1:0]                 dec_left = '0;
  logic [2:0]                 dec_len = '0;

  u8dec_pkg::res_t pending_results[$];
  u8dec_pkg::res_t oldest;
  int unsigned     fail_count = 0;
  int unsigned     quiet_cycles = 0;
  bit              tx_idle_en = 1'b0;
  bit              rx_idle_en = 1'b0;
  int unsigned     rx_hold = 0;

  utf8_stream_decoder_validator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_status       (out_status),
    .out_seq_width    (out_seq_width),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mirrored decoder by one byte; return 1 when a result is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output u8dec_pkg::res_t r);
    logic [u8dec_pkg::CpW-1:0] cp;
    logic [2:0]                w;
    logic [2:0]                min_w;
    bit                        bad_scalar;
    r.code_point = '0;
    r.status     = u8dec_pkg::ST_OK;
    r.seq_width  = '0;
    r.last       = eos;
    if (dec_left == 2'd0) begin
      if (b <= 8'h7F) begin
        r.code_point = {13'd0, b};
        r.seq_width  = 3'd1;
        return 1'b1;
      end
      if (b >= u8dec_pkg::LEAD2_LO && b <= u8dec_pkg::LEAD2_HI) begin
        dec_acc = {16'd0, b[4:0]};
        dec_left = 2'd1;
        dec_len = 3'd2;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        dec_acc = {17'd0, b[3:0]};
        dec_left = 2'd2;
        dec_len = 3'd3;
      end else if (b >= u8dec_pkg::LEAD4_LO && b <= u8dec_pkg::LEAD4_HI) begin
        dec_acc = {18'd0, b[2:0]};
        dec_left = 2'd3;
        dec_len = 3'd4;
      end else begin
        r.status = u8dec_pkg::ST_BAD_START;
        return 1'b1;
      end
      if (eos) begin
        dec_acc = '0;
        dec_left = '0;
        dec_len = '0;
        r.status = u8dec_pkg::ST_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      dec_acc = '0;
      dec_left = '0;
      dec_len = '0;
      r.status = u8dec_pkg::ST_EXPECT_CONT;
      return 1'b1;
    end
    dec_acc = {dec_acc[u8dec_pkg::CpW-7:0], b[5:0]};
    dec_left = dec_left - 2'd1;
    if (dec_left != 2'd0) begin
      if (eos) begin
        dec_acc = '0;
        dec_left = '0;
        dec_len = '0;
        r.status = u8dec_pkg::ST_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end
    cp = dec_acc;
    w = dec_len;
    dec_acc = '0;
    dec_len = '0;
    bad_scalar = (cp > u8dec_pkg::CP_MAX) ||
                 (cp >= u8dec_pkg::SURR_LO && cp <= u8dec_pkg::SURR_HI) ||
                 (cp >= u8dec_pkg::NONCH_LO && cp <= u8dec_pkg::NONCH_HI) ||
                 ((cp[15:0] & u8dec_pkg::NONCH_TAIL) == u8dec_pkg::NONCH_TAIL);
    if (cp <= u8dec_pkg::MAX_W1)
      min_w = 3'd1;
    else if (cp <= u8dec_pkg::MAX_W2)
      min_w = 3'd2;
    else if (cp <= u8dec_pkg::MAX_W3)
      min_w = 3'd3;
    else
      min_w = 3'd4;
    if (bad_scalar) begin
      r.status = u8dec_pkg::ST_BAD_CP;
    end else if (min_w != w) begin
      r.status = u8dec_pkg::ST_OVERLONG;
    end else begin
      r.code_point = cp;
      r.seq_width  = w;
    end
    return 1'b1;
  endfunction

  // Encode cp into w bytes; lead bits above the lead mask are dropped.
  function automatic void encode_cp(input logic [u8dec_pkg::CpW-1:0] cp, input int w,
                                    output logic [7:0] seq[4]);
    logic [u8dec_pkg::CpW-1:0] sh;
    for (int k = 0; k < 4; k++) begin
      sh = cp >> (6 * (w - 1 - k));
      seq[k] = 8'h80 | {2'b00, sh[5:0]};
    end
    sh = cp >> (6 * (w - 1));
    case (w)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = 8'hC0 | {3'b000, sh[4:0]};
      3: seq[0] = 8'hE0 | {4'b0000, sh[3:0]};
      default: seq[0] = 8'hF0 | {5'b00000, sh[2:0]};
    endcase
  endfunction

  // Offer one byte, hold it until the transaction completes, then predict.
  task automatic push_byte(input logic [7:0] b, input logic eos);
    int              gap;
    u8dec_pkg::res_t r;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, eos, r))
      pending_results.push_back(r);
  endtask

  task automatic send_cp(input logic [u8dec_pkg::CpW-1:0] cp, input int w, input logic eos);
    logic [7:0] seq[4];
    encode_cp(cp, w, seq);
    for (int k = 0; k < w; k++)
      push_byte(seq[k], (k == w - 1) ? eos : 1'b0);
  endtask

  // One random unit: mostly well-formed sequences, some broken ones, some noise.
  task automatic random_unit(output int sent);
    int                         pick;
    int                         w;
    int                         cut;
    logic [u8dec_pkg::CpW-1:0]  cp;
    logic [7:0]                 seq[4];
    logic                       eos;
    pick = $urandom_range(0, 99);
    eos = ($urandom_range(0, 5) == 0);
    if (pick < 60) begin
      w = $urandom_range(1, 4);
      case (w)
        1: cp = cp_t'($urandom_range(0, 'h7F));
        2: cp = cp_t'($urandom_range('h80, 'h7FF));
        3: cp = cp_t'($urandom_range('h800, 'hFFFF));
        default: cp = cp_t'($urandom_range('h10000, 'h10FFFF));
      endcase
      send_cp(cp, w, eos);
      sent = w;
    end else if (pick < 70) begin
      case ($urandom_range(0, 3))
        0: begin cp = cp_t'('hD800 + $urandom_range(0, 'h7FF)); w = 3; end
        1: begin cp = cp_t'('hFDD0 + $urandom_range(0, 'h1F)); w = 3; end
        2: begin
          cp = {5'($urandom_range(0, 16)), 16'hFFFE} | cp_t'($urandom_range(0, 1));
          w = (cp > 'hFFFF) ? 4 : 3;
        end
        default: begin cp = cp_t'('h110000 + $urandom_range(0, 'h2FFFF)); w = 4; end
      endcase
      send_cp(cp, w, eos);
      sent = w;
    end else if (pick < 75) begin
      w = $urandom_range(3, 4);
      cp = (w == 3) ? cp_t'($urandom_range(0, 'h7FF)) : cp_t'($urandom_range(0, 'hFFFF));
      send_cp(cp, w, eos);
      sent = w;
    end else if (pick < 87) begin
      // Break a multibyte sequence: end the string early or drop in a non-continuation.
      w = $urandom_range(2, 4);
      cut = $urandom_range(1, w - 1);
      encode_cp(cp_t'($urandom_range('h800, 'h10FFFF) >> (6 * (4 - w) - (w == 4 ? 0 : 0))),
                w, seq);
      if ($urandom_range(0, 1) == 0) begin
        for (int k = 0; k < cut; k++)
          push_byte(seq[k], k == cut - 1);
        sent = cut;
      end else begin
        for (int k = 0; k < cut; k++)
          push_byte(seq[k], 1'b0);
        push_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                       : 8'($urandom_range('hC0, 'hFF)), eos);
        sent = cut + 1;
      end
    end else begin
      push_byte(8'($urandom_range(0, 255)), eos);
      sent = 1;
    end
  endtask

  task automatic test_ascii_and_nul();
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h2A, 1'b0);
  endtask

  task automatic test_well_formed_sequences();
    send_cp('h80, 2, 1'b0);
    send_cp('h800, 3, 1'b0);
    send_cp('h10000, 4, 1'b0);
    send_cp('h10FFFD, 4, 1'b1);
  endtask

  task automatic test_bad_start_bytes();
    push_byte(8'hC0, 1'b0);
    push_byte(8'hF5, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b0);
  endtask

  task automatic test_missing_continuation();
    push_byte(8'hC2, 1'b0);
    push_byte(8'h41, 1'b0);
  endtask

  task automatic test_bad_code_points();
    send_cp('hD800, 3, 1'b0);
    send_cp('hFDD0, 3, 1'b0);
    send_cp('h10FFFF, 4, 1'b0);
  endtask

  task automatic test_overlong_forms();
    send_cp('h7F, 3, 1'b0);
  endtask

  task automatic test_truncated_strings();
    push_byte(8'hF0, 1'b1);
    push_byte(8'hE1, 1'b0);
    push_byte(8'h80, 1'b1);
  endtask

  task automatic test_random_traffic(input int n, input bit tx_idle, input bit rx_idle);
    int total;
    int sent;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    total = 0;
    while (total < n) begin
      random_unit(sent);
      total += sent;
    end
  endtask

  // Stall the result side for a long stretch while input keeps coming.
  task automatic test_output_backpressure();
    rx_hold = HOLD_CYCLES;
    test_random_traffic(150, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_ascii_and_nul();
    test_well_formed_sequences();
    test_bad_start_bytes();
    test_missing_continuation();
    test_bad_code_points();
    test_overlong_forms();
    test_truncated_strings();
    test_random_traffic(900, 1'b1, 1'b1);
    test_random_traffic(250, 1'b0, 1'b0);
    test_output_backpressure();
    test_random_traffic(200, 1'b1, 1'b0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("utf8_stream_decoder_validator verification clean");
    else
      $display("utf8_stream_decoder_validator verification failed");
    $finish;
  end

  initial begin : result_side
    int gap;
    wait (rst_n);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = rx_idle_en ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with none expected: cp=%h status=%0d",
               out_code_point, out_status);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_code_point !== oldest.code_point) begin
          $error("code_point: expected %h, got %h", oldest.code_point, out_code_point);
          fail_count++;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          fail_count++;
        end
        if (out_seq_width !== oldest.seq_width) begin
          $error("seq_width: expected %0d, got %0d", oldest.seq_width, out_seq_width);
          fail_count++;
        end
        if (out_last !== oldest.last) begin
          $error("last: expected %0b, got %0b", oldest.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("utf8_stream_decoder_validator verification failed");
        $finish;
      end
    end
  end

endmodule
